// ===== design/hsfd_pkg.sv =====
// hsfd_pkg: shared types, constants and functions for the humidity frame decoder
// holds the crc-8 byte update and the full-scale divide used by the conversion
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

   // byte index within a measurement frame
   typedef logic [2:0] pos_type;

   localparam pos_type POS_TEMP_HI  = 3'd0;
   localparam pos_type POS_TEMP_LO  = 3'd1;
   localparam pos_type POS_TEMP_CRC = 3'd2;
   localparam pos_type POS_HUM_HI   = 3'd3;
   localparam pos_type POS_HUM_LO   = 3'd4;
   localparam pos_type POS_HUM_CRC  = 3'd5;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam logic [16:0] FULL_SCALE  = 17'd65535;
   localparam logic [30:0] TEMP_SPAN   = 31'd17500;
   localparam logic [30:0] HUM_SPAN    = 31'd10000;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;

   typedef struct packed {
      logic signed [14:0] temperature;
      logic        [13:0] humidity;
   } values_type;

   // msb-first crc-8, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // floor(x / 65535): x = hi*65536 + lo = hi*65535 + (hi + lo), hi + lo < 2*65535
   function automatic logic [14:0] div_full_scale(input logic [30:0] x);
      logic [14:0] hi;
      logic [16:0] sum;
      hi  = x[30:16];
      sum = {2'b00, hi} + {1'b0, x[15:0]};
      return hi + ((sum >= FULL_SCALE) ? 15'd1 : 15'd0);
   endfunction

endpackage

`default_nettype wire

// ===== design/hsfd_convert.sv =====
// hsfd_convert: scales the raw temperature and humidity words to centi-units
// depends on hsfd_pkg for the span constants and the full-scale divide
`timescale 1ns / 1ps
`default_nettype none

module hsfd_convert (
   input  wire logic [15:0]         temp_raw,
   input  wire logic [15:0]         hum_raw,
   output hsfd_pkg::values_type     values
);
   import hsfd_pkg::*;

   logic [30:0] temp_prod;
   logic [30:0] hum_prod;
   logic [14:0] temp_quot;
   logic [14:0] hum_quot;
   logic [14:0] temp_diff;

   assign temp_prod = TEMP_SPAN * {15'd0, temp_raw};
   assign hum_prod  = HUM_SPAN * {15'd0, hum_raw};
   assign temp_quot = div_full_scale(temp_prod);
   assign hum_quot  = div_full_scale(hum_prod);

   // wraps mod 2^15, result stays in -4500..13000
   assign temp_diff = temp_quot - TEMP_OFFSET;

   assign values.temperature = signed'(temp_diff);
   assign values.humidity    = hum_quot[13:0];

endmodule

`default_nettype wire

// ===== design/humidity_sensor_frame_decoder.sv =====
// humidity_sensor_frame_decoder: six-byte measurement frame decoder
//
// the req channel carries one frame byte per word: temp hi, temp lo, temp crc,
// hum hi, hum lo, hum crc. req_frame_start forces the word to be the first
// byte of a frame; without it the position wraps after the sixth byte.
// each word pair is checked with crc-8 (poly 0x31, init 0xff).
// the rsp channel carries one word per frame, registered, in the cycle after
// the sixth byte is accepted: last good temperature and humidity, both crc
// flags and whether the values were refreshed (both crcs good).
// throughput is one byte per cycle unless stalled; crc update and constant scaling
// (a 16x15 multiply per word, a fold-and-correct divide by 65535) are combinational.
// req_stall rises only when the next byte is a sixth byte while a finished result
// still waits under rsp_stall; other bytes are taken regardless.
// reset (synchronous, active high) clears the byte position and the good
// values to zero and sets the crc to 0xff; no result is pending after reset.
// depends on hsfd_pkg and hsfd_convert
`timescale 1ns / 1ps
`default_nettype none

module humidity_sensor_frame_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_frame_start,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [14:0] rsp_temperature_centideg,
   output      logic [13:0]        rsp_humidity_centipct,
   output      logic               rsp_temp_crc_ok,
   output      logic               rsp_hum_crc_ok,
   output      logic               rsp_values_updated
);
   import hsfd_pkg::*;

   pos_type            pos_ff, pos_in;
   logic [7:0]         crc_ff, crc_in;
   logic [15:0]        temp_raw_ff, temp_raw_in;
   logic [15:0]        hum_raw_ff, hum_raw_in;
   logic               temp_pass_ff, temp_pass_in;
   logic signed [14:0] good_temp_ff, good_temp_in;
   logic [13:0]        good_hum_ff, good_hum_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [14:0] rsp_temp_ff, rsp_temp_in;
   logic [13:0]        rsp_hum_ff, rsp_hum_in;
   logic               rsp_temp_ok_ff, rsp_temp_ok_in;
   logic               rsp_hum_ok_ff, rsp_hum_ok_in;
   logic               rsp_upd_ff, rsp_upd_in;

   pos_type            pos_eff;
   logic               is_last;
   logic               accept;
   logic               hum_ok;
   logic               both_ok;
   logic [7:0]         crc_step;
   values_type         conv;

   hsfd_convert u_convert (
      .temp_raw (temp_raw_ff),
      .hum_raw  (hum_raw_ff),
      .values   (conv)
   );

   // unreachable positions behave like the frame start
   assign pos_eff   = (req_frame_start || pos_ff > POS_HUM_CRC) ? POS_TEMP_HI : pos_ff;
   assign is_last   = (pos_eff == POS_HUM_CRC);
   assign req_stall = is_last && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign hum_ok  = (crc_ff == req_rx_byte);
   assign both_ok = temp_pass_ff && hum_ok;

   always_comb begin
      if (pos_eff == POS_TEMP_HI || pos_eff == POS_HUM_HI) begin
         crc_step = crc8_byte(CRC_INIT, req_rx_byte);
      end else begin
         crc_step = crc8_byte(crc_ff, req_rx_byte);
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_raw_in  = temp_raw_ff;
      hum_raw_in   = hum_raw_ff;
      temp_pass_in = temp_pass_ff;
      good_temp_in = good_temp_ff;
      good_hum_in  = good_hum_ff;
      if (accept) begin
         unique case (pos_eff)
            POS_TEMP_HI: begin
               crc_in      = crc_step;
               temp_raw_in = {req_rx_byte, 8'h00};
               pos_in      = POS_TEMP_LO;
            end
            POS_TEMP_LO: begin
               crc_in      = crc_step;
               temp_raw_in = {temp_raw_ff[15:8], req_rx_byte};
               pos_in      = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
               temp_pass_in = (crc_ff == req_rx_byte);
               crc_in       = CRC_INIT;
               pos_in       = POS_HUM_HI;
            end
            POS_HUM_HI: begin
               crc_in     = crc_step;
               hum_raw_in = {req_rx_byte, 8'h00};
               pos_in     = POS_HUM_LO;
            end
            POS_HUM_LO: begin
               crc_in     = crc_step;
               hum_raw_in = {hum_raw_ff[15:8], req_rx_byte};
               pos_in     = POS_HUM_CRC;
            end
            default: begin
               if (both_ok) begin
                  good_temp_in = conv.temperature;
                  good_hum_in  = conv.humidity;
               end
               crc_in = CRC_INIT;
               pos_in = POS_TEMP_HI;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_temp_in    = rsp_temp_ff;
      rsp_hum_in     = rsp_hum_ff;
      rsp_temp_ok_in = rsp_temp_ok_ff;
      rsp_hum_ok_in  = rsp_hum_ok_ff;
      rsp_upd_in     = rsp_upd_ff;
      if (accept && is_last) begin
         rsp_valid_in   = 1'b1;
         rsp_temp_in    = good_temp_in;
         rsp_hum_in     = good_hum_in;
         rsp_temp_ok_in = temp_pass_ff;
         rsp_hum_ok_in  = hum_ok;
         rsp_upd_in     = both_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_TEMP_HI;
         crc_ff       <= CRC_INIT;
         temp_raw_ff  <= '0;
         hum_raw_ff   <= '0;
         temp_pass_ff <= 1'b0;
         good_temp_ff <= '0;
         good_hum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_raw_ff  <= temp_raw_in;
         hum_raw_ff   <= hum_raw_in;
         temp_pass_ff <= temp_pass_in;
         good_temp_ff <= good_temp_in;
         good_hum_ff  <= good_hum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff    <= rsp_temp_in;
      rsp_hum_ff     <= rsp_hum_in;
      rsp_temp_ok_ff <= rsp_temp_ok_in;
      rsp_hum_ok_ff  <= rsp_hum_ok_in;
      rsp_upd_ff     <= rsp_upd_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_temperature_centideg = rsp_temp_ff;
   assign rsp_humidity_centipct    = rsp_hum_ff;
   assign rsp_temp_crc_ok          = rsp_temp_ok_ff;
   assign rsp_hum_crc_ok           = rsp_hum_ok_ff;
   assign rsp_values_updated       = rsp_upd_ff;

`ifndef SYNTHESIS
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && is_last))
      else $error("req_stall without a blocked result");

   a_update_needs_both_crcs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_upd_ff) |-> (rsp_temp_ok_ff && rsp_hum_ok_ff))
      else $error("values refreshed with a failing crc");

   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_HUM_CRC)
      else $error("byte position out of range");

   a_result_after_last_byte: assert property (@(posedge clock) disable iff (reset)
      (accept && is_last) |=> rsp_valid_ff)
      else $error("sixth byte gave no result");
`endif

endmodule

`default_nettype wire
